### rtl/hamming_best_match_ratio_test_top_assert.svh
// Assertion macros for the Hamming best-match block.
// Used by the port checker; no other dependencies.
`ifndef HAMMING_BEST_MATCH_RATIO_TEST_TOP_ASSERT_SVH
`define HAMMING_BEST_MATCH_RATIO_TEST_TOP_ASSERT_SVH

// Clocked property, ignored while reset is asserted
`define HBMRT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds during reset
`define HBMRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hbmrt_pkg.sv
// Shared types, constants and the 64-bit popcount for the Hamming
// best-match block. No dependencies.
`default_nettype none

package hbmrt_pkg;

  localparam int DescWords = 4;
  localparam int WordW     = 64;
  localparam int IdxW      = 11;
  localparam int LvlInW    = 3;
  localparam int LvlW      = 4;
  localparam int DistW     = 9;
  localparam int CntW      = 7;
  localparam int RatioW    = 9;
  localparam int QDepth    = 4;
  localparam int QPtrW     = 2;
  localparam int QCntW     = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 9;
  localparam int InDataW   = 272;
  localparam int InUserW   = 2;
  localparam int OutDataW  = 32;

  localparam logic [DistW-1:0]  DIST_NONE      = 9'd256;
  localparam logic [LvlW-1:0]   LEVEL_NONE     = 4'd15;
  localparam logic [DistW-1:0]  DIST_LIMIT_RST = 9'd50;
  localparam logic [RatioW-1:0] RATIO_RST      = 9'd154;

  typedef enum logic {
    KIND_QUERY = 1'b0,
    KIND_CAND  = 1'b1
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIST_LIMIT = 3'd0,
    CFG_RATIO_Q8   = 3'd1,
    CFG_RATIO_EN   = 3'd2,
    CFG_SAME_LVL   = 3'd3,
    CFG_INCL       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DistW-1:0]  dist_limit;
    logic [RatioW-1:0] ratio_q8;
    logic              ratio_en;
    logic              same_lvl;
    logic              incl;
  } cfg_t;

  // One classified item between front and back
  typedef struct packed {
    kind_t            kind;
    logic [DistW-1:0] hdist;
    logic [IdxW-1:0]  idx;
    logic [LvlW-1:0]  lvl;
    logic             skip;
    logic             last;
  } qent_t;

  // Best / second-best tracker
  typedef struct packed {
    logic [DistW-1:0] best_dist;
    logic [DistW-1:0] second_dist;
    logic [LvlW-1:0]  best_lvl;
    logic [LvlW-1:0]  second_lvl;
    logic [IdxW-1:0]  best_idx;
  } trk_t;

  localparam trk_t TRK_CLEAR = '{
    best_dist:   DIST_NONE,
    second_dist: DIST_NONE,
    best_lvl:    LEVEL_NONE,
    second_lvl:  LEVEL_NONE,
    best_idx:    '0
  };

  // SWAR popcount, then a byte sum
  function automatic logic [CntW-1:0] popcount64(input logic [WordW-1:0] v);
    logic [WordW-1:0] v1;
    logic [WordW-1:0] v2;
    logic [WordW-1:0] v3;
    logic [CntW-1:0]  sum;
    v1  = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    v2  = (v1 & 64'h3333_3333_3333_3333) + ((v1 >> 2) & 64'h3333_3333_3333_3333);
    v3  = (v2 + (v2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    sum = '0;
    for (int b = 0; b < 8; b++) begin
      sum = sum + CntW'(v3[b*8 +: 8]);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

### rtl/hamming_best_match_ratio_test_top.sv
// Top level of the Hamming best-match search with ratio test.
// Depends on hbmrt_pkg, hbmrt_front, hbmrt_queue and hbmrt_back.
//
//  port group | dir | beat contents
//  in_*       | in  | query load or candidate, tlast ends a search
//  out_*      | out | one result per search
//  cfg_*      | in  | register write, no read-back
//
// One beat per cycle while the queue has room. A result beat is registered in
// turn in the count stage, queue, snapshot and output after its last candidate.
// Only a final candidate waits at the queue head, and only while both the
// snapshot and output registers are full; the input stalls once the queue
// plus the count stage hold four items, i.e. when the result side holds back.
// Reset is synchronous, active low; it clears the query, trackers and
// registers to their defaults.
`default_nettype none

module hamming_best_match_ratio_test_top #(
  parameter int MAX_FEATURES = 2048,
  parameter int NUM_LEVELS   = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // desc_w0, desc_w1, desc_w2, desc_w3, cand_index, cand_level, 2 pad bits
  input  wire logic [hbmrt_pkg::InDataW-1:0]   in_tdata,
  // req_type, cand_skip
  input  wire logic [hbmrt_pkg::InUserW-1:0]   in_tuser,
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // best_index, best_distance, second_distance, 3 pad bits
  output logic [hbmrt_pkg::OutDataW-1:0]       out_tdata,
  // matched
  output logic                                 out_tuser,
  input  wire logic                            cfg_we,
  input  wire logic [hbmrt_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [hbmrt_pkg::CfgDataW-1:0]  cfg_wdata
);
  import hbmrt_pkg::*;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic             push;
  qent_t            push_ent;
  logic             pop;
  logic             pop_valid;
  qent_t            pop_ent;
  logic [QCntW-1:0] q_count;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DIST_LIMIT: cfg_nxt.dist_limit = cfg_wdata;
        CFG_RATIO_Q8:   cfg_nxt.ratio_q8   = cfg_wdata;
        CFG_RATIO_EN:   cfg_nxt.ratio_en   = cfg_wdata[0];
        CFG_SAME_LVL:   cfg_nxt.same_lvl   = cfg_wdata[0];
        CFG_INCL:       cfg_nxt.incl       = cfg_wdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dist_limit <= DIST_LIMIT_RST;
      cfg_r.ratio_q8   <= RATIO_RST;
      cfg_r.ratio_en   <= 1'b1;
      cfg_r.same_lvl   <= 1'b0;
      cfg_r.incl       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hbmrt_front #(
    .MAX_FEATURES (MAX_FEATURES),
    .NUM_LEVELS   (NUM_LEVELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_count   (q_count),
    .push      (push),
    .push_ent  (push_ent)
  );

  hbmrt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ent  (push_ent),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_ent   (pop_ent),
    .count     (q_count)
  );

  hbmrt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (pop_valid),
    .q_ent      (pop_ent),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### rtl/hbmrt_front.sv
// Front end: holds the query descriptor, takes input beats, computes the
// per-word distance counts and pushes classified items. Uses hbmrt_pkg.
`default_nettype none

module hbmrt_front #(
  parameter int MAX_FEATURES = 2048,
  parameter int NUM_LEVELS   = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [hbmrt_pkg::InDataW-1:0] in_tdata,
  input  wire logic [hbmrt_pkg::InUserW-1:0] in_tuser,
  input  wire logic                          in_tlast,
  input  wire logic [hbmrt_pkg::QCntW-1:0]   q_count,
  output logic                               push,
  output hbmrt_pkg::qent_t                   push_ent
);
  import hbmrt_pkg::*;

  localparam logic [IdxW-1:0] IdxMask = IdxW'(MAX_FEATURES - 1);
  localparam logic [LvlW-1:0] LvlMax  = LvlW'(NUM_LEVELS - 1);

  logic [WordW-1:0] query_r [DescWords];
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [CntW-1:0]  cnt_r   [DescWords];
  logic [CntW-1:0]  cnt_nxt [DescWords];
  kind_t            kind_r;
  logic [IdxW-1:0]  idx_r;
  logic [LvlW-1:0]  lvl_r;
  logic [LvlW-1:0]  lvl_nxt;
  logic             skip_r;
  logic             last_r;
  logic             accept;
  logic [LvlW-1:0]  lvl_in;

  // room for this beat plus the one in the count stage
  assign in_tready = (QCntW'(q_count) + QCntW'(s1_valid_r)) < QCntW'(QDepth);
  assign accept    = in_tvalid && in_tready;

  // per-word XOR popcount against the current query
  always_comb begin
    for (int w = 0; w < DescWords; w++) begin
      cnt_nxt[w] = popcount64(query_r[w] ^ in_tdata[w*WordW +: WordW]);
    end
  end

  // level saturation
  assign lvl_in  = {1'b0, in_tdata[DescWords*WordW + IdxW +: LvlInW]};
  assign lvl_nxt = (lvl_in > LvlMax) ? LvlMax : lvl_in;
  assign s1_valid_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      for (int w = 0; w < DescWords; w++) begin
        query_r[w] <= '0;
      end
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept && (in_tuser[0] == KIND_QUERY)) begin
        for (int w = 0; w < DescWords; w++) begin
          query_r[w] <= in_tdata[w*WordW +: WordW];
        end
      end
    end
  end

  // count stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r  <= cnt_nxt;
      kind_r <= kind_t'(in_tuser[0]);
      idx_r  <= in_tdata[DescWords*WordW +: IdxW] & IdxMask;
      lvl_r  <= lvl_nxt;
      skip_r <= in_tuser[1];
      last_r <= in_tlast;
    end
  end

  // final sum and push into the queue
  assign push = s1_valid_r;
  always_comb begin
    push_ent.kind  = kind_r;
    push_ent.hdist = DistW'(cnt_r[0]) + DistW'(cnt_r[1]) + DistW'(cnt_r[2])
                   + DistW'(cnt_r[3]);
    push_ent.idx   = idx_r;
    push_ent.lvl   = lvl_r;
    push_ent.skip  = skip_r;
    push_ent.last  = last_r;
  end

endmodule

`default_nettype wire

### rtl/hbmrt_queue.sv
// Short FIFO of classified items between front and back. Uses hbmrt_pkg.
`default_nettype none

module hbmrt_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  hbmrt_pkg::qent_t                 push_ent,
  input  wire logic                        pop,
  output logic                             pop_valid,
  output hbmrt_pkg::qent_t                 pop_ent,
  output logic [hbmrt_pkg::QCntW-1:0]      count
);
  import hbmrt_pkg::*;

  qent_t            mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QPtrW-1:0] rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r;
  logic [QCntW-1:0] cnt_nxt;

  assign pop_valid = (cnt_r != '0);
  assign pop_ent   = mem_r[rd_ptr_r];
  assign count     = cnt_r;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

`default_nettype wire

### rtl/hbmrt_back.sv
// Back end: best / second-best tracking, result snapshot, ratio test and
// the output register. Uses hbmrt_pkg.
`default_nettype none

module hbmrt_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  hbmrt_pkg::cfg_t                     cfg,
  input  wire logic                           q_valid,
  input  hbmrt_pkg::qent_t                    q_ent,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [hbmrt_pkg::OutDataW-1:0]      out_tdata,
  output logic                                out_tuser
);
  import hbmrt_pkg::*;

  trk_t                trk_r;
  trk_t                trk_nxt;
  trk_t                upd;
  trk_t                snap_r;
  logic                snap_valid_r;
  logic                snap_valid_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                matched_r;
  logic                matched_nxt;
  logic [IdxW-1:0]     out_idx_r;
  logic [DistW-1:0]    out_best_r;
  logic [DistW-1:0]    out_second_r;
  logic                out_free;
  logic                snap_ready;
  logic                is_final;
  logic                ok;
  logic                apply;
  logic [17:0]         lhs;
  logic [17:0]         rhs;

  assign out_free   = !out_valid_r || out_tready;
  assign snap_ready = !snap_valid_r || out_free;
  assign is_final   = (q_ent.kind == KIND_CAND) && q_ent.last;
  assign q_pop      = q_valid && (!is_final || snap_ready);

  // tracker update for the item at the queue head
  always_comb begin
    upd = trk_r;
    if ((q_ent.kind == KIND_CAND) && !q_ent.skip) begin
      if (q_ent.hdist < trk_r.best_dist) begin
        upd.second_dist = trk_r.best_dist;
        upd.second_lvl  = trk_r.best_lvl;
        upd.best_dist   = q_ent.hdist;
        upd.best_lvl    = q_ent.lvl;
        upd.best_idx    = q_ent.idx;
      end else if (q_ent.hdist < trk_r.second_dist) begin
        upd.second_dist = q_ent.hdist;
        upd.second_lvl  = q_ent.lvl;
      end
    end
  end

  // a query or a finished search starts the trackers over
  always_comb begin
    trk_nxt = trk_r;
    if (q_pop) begin
      if ((q_ent.kind == KIND_QUERY) || q_ent.last) begin
        trk_nxt = TRK_CLEAR;
      end else begin
        trk_nxt = upd;
      end
    end
  end

  always_comb begin
    if (q_pop && is_final) begin
      snap_valid_nxt = 1'b1;
    end else if (out_free) begin
      snap_valid_nxt = 1'b0;
    end else begin
      snap_valid_nxt = snap_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r        <= TRK_CLEAR;
      snap_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      trk_r        <= trk_nxt;
      snap_valid_r <= snap_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && is_final) begin
      snap_r <= upd;
    end
  end

  // distance limit and ratio test on the snapshot
  always_comb begin
    lhs   = {snap_r.best_dist, 8'd0} + 18'd0;
    rhs   = 18'(snap_r.second_dist) * 18'(cfg.ratio_q8);
    ok    = (snap_r.best_lvl != LEVEL_NONE) && (snap_r.best_dist <= cfg.dist_limit);
    apply = cfg.ratio_en && (!cfg.same_lvl || (snap_r.best_lvl == snap_r.second_lvl));
    matched_nxt = ok;
    if (ok && apply) begin
      matched_nxt = cfg.incl ? (lhs <= rhs) : (lhs < rhs);
    end
  end

  assign out_valid_nxt = (snap_valid_r && out_free) ? 1'b1 :
                         (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (snap_valid_r && out_free) begin
      matched_r    <= matched_nxt;
      out_idx_r    <= snap_r.best_idx;
      out_best_r   <= snap_r.best_dist;
      out_second_r <= snap_r.second_dist;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = matched_r;
  assign out_tdata  = {3'b000, out_second_r, out_best_r, out_idx_r};

endmodule

`default_nettype wire

### rtl/hbmrt_checker.sv
// Port-level checks on the result channel of the top level, and the bind
// that attaches them. Uses the assertion macro header.
`default_nettype none
`include "hamming_best_match_ratio_test_top_assert.svh"

module hbmrt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  // a stalled result beat holds
  `HBMRT_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // best never exceeds second
  `HBMRT_ASSERT(a_best_le_second, clk, rst_n, out_tvalid |-> out_tdata[19:11] <= out_tdata[28:20], "best distance above second")

  // a match needs a real best candidate
  `HBMRT_ASSERT(a_match_has_best, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[19:11] != 9'd256, "match without candidate")

  // no result right after reset
  `HBMRT_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind hamming_best_match_ratio_test_top hbmrt_checker u_hbmrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

### tb/hamming_best_match_ratio_test_tb.sv
// Testbench for the Hamming best-match search with ratio test.
// Drives query and candidate beats, predicts each search result in a small
// scoreboard class. Depends on hbmrt_pkg and hamming_best_match_ratio_test_top.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbmrt_pkg::*;

  localparam int MAX_FEATURES = 2048;
  localparam int NUM_LEVELS   = 8;
  localparam int DESC_W       = DescWords * WordW;
  localparam int DRAIN_CYC    = 20;
  localparam int MAX_CYCLES   = 400000;
  localparam int PHASE_ITEMS  = 225;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // desc_w0, desc_w1, desc_w2, desc_w3, cand_index, cand_level, 2 pad bits
  logic [InDataW-1:0]    in_tdata = '0;
  // req_type, cand_skip
  logic [InUserW-1:0]    in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // best_index, best_distance, second_distance, 3 pad bits
  logic [OutDataW-1:0]   out_tdata;
  // matched
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index = '0;
  logic [CfgDataW-1:0]   cfg_wdata = '0;

  bit          quiet;      // no idling on either side
  bit          hold_req;   // receiver holds off for a long stretch
  int          cycles;
  bit [DESC_W-1:0] cur_q;  // query the block currently holds

  hamming_best_match_ratio_test_top #(
    .MAX_FEATURES(MAX_FEATURES),
    .NUM_LEVELS  (NUM_LEVELS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Tracks best/second distances per search and queues the expected results
  class best_match_tracker;
    typedef struct {
      bit             matched;
      bit [IdxW-1:0]  best_index;
      bit [DistW-1:0] best_distance;
      bit [DistW-1:0] second_distance;
    } match_t;

    match_t pending[$];

    bit [DESC_W-1:0] query;
    bit [DistW-1:0]  best_d;
    bit [DistW-1:0]  second_d;
    bit [LvlW-1:0]   best_l;
    bit [LvlW-1:0]   second_l;
    bit [IdxW-1:0]   best_i;

    bit [DistW-1:0]  dist_limit;
    bit [RatioW-1:0] ratio_q8;
    bit              ratio_en;
    bit              same_lvl;
    bit              incl;
    int              mismatches;

    function new();
      query      = '0;
      dist_limit = DIST_LIMIT_RST;
      ratio_q8   = RATIO_RST;
      ratio_en   = 1'b1;
      same_lvl   = 1'b0;
      incl       = 1'b0;
      mismatches = 0;
      clear_search();
    endfunction

    function void clear_search();
      best_d   = DIST_NONE;
      second_d = DIST_NONE;
      best_l   = LEVEL_NONE;
      second_l = LEVEL_NONE;
      best_i   = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
      case (idx)
        CFG_DIST_LIMIT: dist_limit = v;
        CFG_RATIO_Q8:   ratio_q8   = v;
        CFG_RATIO_EN:   ratio_en   = v[0];
        CFG_SAME_LVL:   same_lvl   = v[0];
        CFG_INCL:       incl       = v[0];
        default: ;
      endcase
    endfunction

    // Accepted input beat: update trackers, queue a result on last
    function void absorb(kind_t kind, bit [DESC_W-1:0] desc, bit [IdxW-1:0] idx,
                         bit [LvlInW-1:0] lvl, bit skip, bit last);
      int            d;
      int            lhs;
      int            rhs;
      bit [LvlW-1:0] lv;
      bit [IdxW-1:0] ix;
      bit            ok;
      bit            apply;
      match_t        m;
      if (kind == KIND_QUERY) begin
        query = desc;
        clear_search();
        return;
      end
      lv = LvlW'(lvl);
      if (lv > NUM_LEVELS - 1) lv = LvlW'(NUM_LEVELS - 1);
      ix = idx & IdxW'(MAX_FEATURES - 1);
      if (!skip) begin
        d = $countones(query ^ desc);
        if (d < best_d) begin
          second_d = best_d;
          second_l = best_l;
          best_d   = DistW'(d);
          best_l   = lv;
          best_i   = ix;
        end else if (d < second_d) begin
          second_d = DistW'(d);
          second_l = lv;
        end
      end
      if (!last) return;
      ok    = (best_l != LEVEL_NONE) && (best_d <= dist_limit);
      apply = ratio_en && (!same_lvl || best_l == second_l);
      if (ok && apply) begin
        lhs = int'(best_d) * 256;
        rhs = int'(ratio_q8) * int'(second_d);
        ok  = incl ? (lhs <= rhs) : (lhs < rhs);
      end
      m.matched         = ok;
      m.best_index      = best_i;
      m.best_distance   = best_d;
      m.second_distance = second_d;
      pending = {pending, m};
      clear_search();
    endfunction

    // Accepted result beat against the oldest expectation
    function void compare(logic matched, logic [OutDataW-1:0] data);
      match_t         m;
      logic [IdxW-1:0]  bi;
      logic [DistW-1:0] bd;
      logic [DistW-1:0] sd;
      if (pending.size() == 0) begin
        $error("result beat with no search pending: tdata %h tuser %b", data, matched);
        mismatches++;
        return;
      end
      m  = pending.pop_front();
      bi = data[IdxW-1:0];
      bd = data[IdxW +: DistW];
      sd = data[IdxW+DistW +: DistW];
      if (matched !== m.matched) begin
        $error("matched: expected %0d, actual %0d", m.matched, matched);
        mismatches++;
      end
      if (bi !== m.best_index) begin
        $error("best_index: expected %0d, actual %0d", m.best_index, bi);
        mismatches++;
      end
      if (bd !== m.best_distance) begin
        $error("best_distance: expected %0d, actual %0d", m.best_distance, bd);
        mismatches++;
      end
      if (sd !== m.second_distance) begin
        $error("second_distance: expected %0d, actual %0d", m.second_distance, sd);
        mismatches++;
      end
    endfunction
  endclass

  best_match_tracker sb = new();

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.compare(out_tuser, out_tdata);
  end

  // Receiver backpressure: random bursts, one long hold-off on request
  initial begin
    forever begin
      if (quiet) begin
        out_tready <= 1'b1;
        @(negedge clk);
      end else if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(3, 0) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 1)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 1)) @(negedge clk);
      end
    end
  end

  function automatic bit [DESC_W-1:0] rand_desc();
    bit [DESC_W-1:0] r;
    for (int w = 0; w < DESC_W / 32; w++) r[w*32 +: 32] = $urandom;
    return r;
  endfunction

  // base with exactly k bits flipped, a contiguous run at a random offset
  function automatic bit [DESC_W-1:0] near(bit [DESC_W-1:0] base, int k);
    bit [DESC_W-1:0] m;
    int              r;
    m = '0;
    for (int i = 0; i < k; i++) m[i] = 1'b1;
    r = $urandom_range(DESC_W - 1, 0);
    if (r != 0) m = (m << r) | (m >> (DESC_W - r));
    return base ^ m;
  endfunction

  // One input beat; entered and left at a falling edge
  task automatic send_item(kind_t kind, bit [DESC_W-1:0] desc, bit [IdxW-1:0] idx,
                           bit [LvlInW-1:0] lvl, bit skip, bit last);
    if (!quiet && $urandom_range(3, 0) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, lvl, idx, desc};
    in_tuser  <= {skip, kind};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.absorb(kind, desc, idx, lvl, skip, last);
    @(negedge clk);
  endtask

  // Stop offering, wait for all results, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_one(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  // All registers plus one write to an unused index; block must be idle
  task automatic program_regs(bit [DistW-1:0] limit, bit [RatioW-1:0] ratio,
                              bit en, bit same, bit inc);
    write_one(CFG_DIST_LIMIT, limit);
    write_one(CFG_RATIO_Q8, ratio);
    write_one(CFG_RATIO_EN, {8'($urandom), en});
    write_one(CFG_SAME_LVL, {8'($urandom), same});
    write_one(CFG_INCL, {8'($urandom), inc});
    write_one(CFG_INCL + CfgIdxW'($urandom_range(3, 1)), CfgDataW'($urandom));
    cfg_we <= 1'b0;
  endtask

  // One search: optional new query, a run of candidates, usually ending in last
  task automatic run_search();
    int              n;
    bit              broken;
    bit [DESC_W-1:0] desc;
    bit [LvlInW-1:0] lvl;
    if ($urandom_range(7, 0) != 0) begin
      cur_q = rand_desc();
      send_item(KIND_QUERY, cur_q, IdxW'($urandom), LvlInW'($urandom),
                $urandom_range(1, 0), $urandom_range(1, 0));
    end
    n      = $urandom_range(8, 1);
    broken = ($urandom_range(15, 0) == 0);
    for (int c = 0; c < n; c++) begin
      case ($urandom_range(9, 0))
        0:       desc = rand_desc();
        1:       desc = near(cur_q, $urandom_range(DESC_W, 0));
        default: desc = near(cur_q, $urandom_range(40, 0));
      endcase
      // crowd levels together so the same-level rule bites
      lvl = ($urandom_range(1, 0) == 0) ? LvlInW'($urandom_range(1, 0)) : LvlInW'($urandom);
      send_item(KIND_CAND, desc, IdxW'($urandom), lvl, $urandom_range(7, 0) == 0,
                (c == n - 1) && !broken);
    end
  endtask

  // Stimulus
  initial begin
    bit [DistW-1:0]  limit;
    bit [RatioW-1:0] ratio;
    int              sent;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset register values; candidate before any query meets the zero query
    cur_q = '0;
    send_item(KIND_CAND, '0, IdxW'(MAX_FEATURES - 1), LvlInW'(NUM_LEVELS - 1), 1'b0, 1'b1);
    // skipped candidate with last: nothing kept, result still comes
    send_item(KIND_CAND, rand_desc(), '0, '0, 1'b1, 1'b1);
    // last on a query is ignored
    cur_q = '1;
    send_item(KIND_QUERY, cur_q, '0, '0, 1'b0, 1'b1);
    // distance 256 is never recorded
    send_item(KIND_CAND, '0, IdxW'(3), LvlInW'(1), 1'b0, 1'b1);
    // ties go to second, skipped last still reports
    cur_q = rand_desc();
    send_item(KIND_QUERY, cur_q, '0, '0, 1'b0, 1'b0);
    send_item(KIND_CAND, near(cur_q, 3), IdxW'(5), LvlInW'(2), 1'b0, 1'b0);
    send_item(KIND_CAND, near(cur_q, 3), IdxW'(9), LvlInW'(3), 1'b0, 1'b0);
    send_item(KIND_CAND, near(cur_q, 40), IdxW'(11), LvlInW'(4), 1'b1, 1'b1);
    // new run against the kept query
    send_item(KIND_CAND, cur_q, '0, '0, 1'b0, 1'b0);
    send_item(KIND_CAND, near(cur_q, 100), '1, LvlInW'(5), 1'b0, 1'b1);

    // Inclusive equality and the same-level rule
    drain();
    program_regs(DistW'(256), RatioW'(128), 1'b1, 1'b1, 1'b1);
    cur_q = '0;
    send_item(KIND_QUERY, cur_q, '0, '0, 1'b0, 1'b0);
    send_item(KIND_CAND, near(cur_q, 5), IdxW'(1), LvlInW'(1), 1'b0, 1'b0);
    send_item(KIND_CAND, near(cur_q, 10), IdxW'(2), LvlInW'(1), 1'b0, 1'b1);
    send_item(KIND_CAND, near(cur_q, 5), IdxW'(3), LvlInW'(1), 1'b0, 1'b0);
    send_item(KIND_CAND, near(cur_q, 10), IdxW'(4), LvlInW'(2), 1'b0, 1'b1);

    // Zero limit and zero ratio
    drain();
    program_regs('0, '0, 1'b1, 1'b0, 1'b0);
    send_item(KIND_CAND, near(cur_q, 5), IdxW'(6), LvlInW'(3), 1'b0, 1'b0);
    send_item(KIND_CAND, near(cur_q, 10), IdxW'(7), LvlInW'(3), 1'b0, 1'b1);
    send_item(KIND_CAND, cur_q, IdxW'(8), LvlInW'(4), 1'b0, 1'b1);

    // Ratio test off, full limit
    drain();
    program_regs(DistW'(256), RatioW'(256), 1'b0, 1'b0, 1'b0);
    send_item(KIND_CAND, '1, IdxW'(10), LvlInW'(6), 1'b0, 1'b0);
    send_item(KIND_CAND, near(cur_q, 255), IdxW'(12), LvlInW'(7), 1'b0, 1'b1);

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 7; phase++) begin
      drain();
      case ($urandom_range(2, 0))
        0:       limit = '0;
        1:       limit = DistW'(256);
        default: limit = DistW'($urandom_range(120, 20));
      endcase
      case ($urandom_range(2, 0))
        0:       ratio = '0;
        1:       ratio = RatioW'(256);
        default: ratio = RatioW'($urandom_range(230, 100));
      endcase
      program_regs(limit, ratio, $urandom_range(3, 0) != 0, $urandom_range(1, 0),
                   $urandom_range(1, 0));
      if (phase == 2 || phase == 5) hold_req = 1'b1;
      if (phase == 6) quiet = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        run_search();
        sent += 5;
      end
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
